// File: sv/two_level_page_table_manager_assert.svh
// Assertion macros for the two-level page table manager.
// Used by the top level only; expects i_clk and i_rst_n in the including module.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH

// property checked at every clock edge out of reset
`define TPLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// antecedent now, consequent in the next cycle
`define TPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tplm_pkg.sv
// Shared types and constants for the two-level page table manager.
// No dependencies.
package tplm_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_SLOTS   = 16;
    localparam int IDX_W         = 10;   // bits of a directory or table index
    localparam int FRAME_W       = 20;   // page frame number bits
    localparam int CNT_W         = 11;   // present count, holds TABLE_ENTRIES

    localparam logic CFG_KSTART = 1'b0;
    localparam logic CFG_KEND   = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_KERNEL   = 3'd1;
    localparam logic [2:0] ST_NO_TABLE = 3'd2;
    localparam logic [2:0] ST_NOT_MAP  = 3'd3;
    localparam logic [2:0] ST_NO_ALLOC = 3'd4;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_KCHK1, S_KCHK2, S_DIR, S_DIRW,
        S_SRCH, S_CLR, S_TRD, S_TRW, S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        borrow;
    } t_alu_rsp;

endpackage

// File: sv/tplm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tplm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tplm_alu.sv
// Shared add/subtract unit: index steps, count updates, kernel range compares.
// Depends on tplm_pkg.
module tplm_alu (
    input  tplm_pkg::t_alu_req i_req,
    output tplm_pkg::t_alu_rsp o_rsp
);

    logic [32:0] sum;

    always_comb begin
        if (i_req.sub) begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res    = sum[31:0];
        o_rsp.borrow = sum[32];   // on subtract: a < b
    end

endmodule

// File: sv/two_level_page_table_manager.sv
// Top level of the two-level page table manager: sequencer, directory,
// table and count RAMs. Depends on tplm_pkg, tplm_ram, tplm_alu and the assert header.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  request  | in        | i_valid / o_ready   | op, virtual/physical addr, spare
//  result   | out       | o_valid / i_ready   | status, flags, freed addresses
//  config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// A transaction passes through the kernel check (map only), the directory read, the table
// read and write and the output state, and returns to idle before the next is taken; a map
// that creates a table first searches the free slots and clears the new table.
// After reset a clearing pass builds the directory and the identity
// table; no request is taken during it. Every step goes through the one adder.
// A finished result waits in the output register while the next request runs.
module two_level_page_table_manager #(
    parameter int TABLE_SLOTS = tplm_pkg::TABLE_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [31:0] i_virtual_address,
    input  logic [31:0] i_physical_address,
    input  logic [31:0] i_spare_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_spare_taken,
    output logic        o_invalidate,
    output logic        o_freed_page_valid,
    output logic [31:0] o_freed_page_addr,
    output logic        o_freed_table_valid,
    output logic [31:0] o_freed_table_addr
);

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int IW  = tplm_pkg::IDX_W;
    localparam int FW  = tplm_pkg::FRAME_W;
    localparam int CW  = tplm_pkg::CNT_W;
    localparam int DW  = FW + SW + 2;
    localparam int TW  = FW + 1;
    localparam int TD  = TABLE_SLOTS * tplm_pkg::TABLE_ENTRIES;

    tplm_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_op;
    logic [31:0]      r_va, r_pa, r_spare;
    logic [31:0]      r_kstart, r_kend;
    logic             r_ge, n_ge;
    logic             r_dpres, n_dpres;
    logic [FW-1:0]    r_dframe, n_dframe;
    logic [SW-1:0]    r_dslot, n_dslot;
    logic             r_ddyn, n_ddyn;
    logic [SW-1:0]    r_slot, n_slot;
    logic [TABLE_SLOTS-1:0] r_busy, n_busy;

    // pending result
    logic [2:0]       r_status, n_status;
    logic             r_taken, n_taken, r_inval, n_inval;
    logic             r_fpv, n_fpv, r_ftv, n_ftv;
    logic [FW-1:0]    r_fpa, n_fpa, r_fta, n_fta;

    // output register
    logic             r_ovalid, n_ovalid, out_load;
    logic [2:0]       r_ostatus;
    logic             r_otaken, r_oinval, r_ofpv, r_oftv;
    logic [FW-1:0]    r_ofpa, r_ofta;

    // memories
    logic            dir_we;
    logic [IW-1:0]   dir_waddr;
    logic [DW-1:0]   dir_wdata, dir_rdata;
    logic            tab_we;
    logic [SW+IW-1:0] tab_waddr;
    logic [TW-1:0]   tab_wdata, tab_rdata;
    logic            cnt_we;
    logic [SW-1:0]   cnt_waddr;
    logic [CW-1:0]   cnt_wdata, cnt_rdata;

    tplm_pkg::t_alu_req alu_req;
    tplm_pkg::t_alu_rsp alu_rsp;

    logic [CW-1:0]   cnt_dec;

    tplm_ram #(.WIDTH(DW), .DEPTH(tplm_pkg::TABLE_ENTRIES)) u_dir (
        .i_clk(i_clk), .i_we(dir_we), .i_waddr(dir_waddr), .i_wdata(dir_wdata),
        .i_raddr(r_va[31:22]), .o_rdata(dir_rdata)
    );

    tplm_ram #(.WIDTH(TW), .DEPTH(TD)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr({r_dslot, r_va[21:12]}), .o_rdata(tab_rdata)
    );

    tplm_ram #(.WIDTH(CW), .DEPTH(TABLE_SLOTS)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(r_dslot), .o_rdata(cnt_rdata)
    );

    tplm_alu u_alu (.i_req(alu_req), .o_rsp(alu_rsp));

    assign o_ready = (r_state == tplm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kstart <= '0;
            r_kend   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tplm_pkg::CFG_KSTART: r_kstart <= i_cfg_data;
                tplm_pkg::CFG_KEND:   r_kend   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tplm_pkg::S_INIT;
            r_idx    <= '0;
            r_busy   <= TABLE_SLOTS'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_op;
            r_va    <= i_virtual_address;
            r_pa    <= i_physical_address;
            r_spare <= i_spare_frame;
        end
        r_ge     <= n_ge;
        r_dpres  <= n_dpres;
        r_dframe <= n_dframe;
        r_dslot  <= n_dslot;
        r_ddyn   <= n_ddyn;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_taken  <= n_taken;
        r_inval  <= n_inval;
        r_fpv    <= n_fpv;
        r_fpa    <= n_fpa;
        r_ftv    <= n_ftv;
        r_fta    <= n_fta;
        if (out_load) begin
            r_ostatus <= r_status;
            r_otaken  <= r_taken;
            r_oinval  <= r_inval;
            r_ofpv    <= r_fpv;
            r_ofpa    <= r_fpa;
            r_oftv    <= r_ftv;
            r_ofta    <= r_fta;
        end
    end

    assign cnt_dec = (cnt_rdata == '0) ? '0 : alu_rsp.res[CW-1:0];

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_busy   = r_busy;
        n_ge     = r_ge;
        n_dpres  = r_dpres;
        n_dframe = r_dframe;
        n_dslot  = r_dslot;
        n_ddyn   = r_ddyn;
        n_slot   = r_slot;
        n_status = r_status;
        n_taken  = r_taken;
        n_inval  = r_inval;
        n_fpv    = r_fpv;
        n_fpa    = r_fpa;
        n_ftv    = r_ftv;
        n_fta    = r_fta;
        out_load = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        dir_we    = 1'b0;
        dir_waddr = r_va[31:22];
        dir_wdata = '0;
        tab_we    = 1'b0;
        tab_waddr = {r_dslot, r_va[21:12]};
        tab_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = r_dslot;
        cnt_wdata = '0;
        alu_req.a   = 32'(r_idx);
        alu_req.b   = 32'd1;
        alu_req.sub = 1'b0;

        case (r_state)
            tplm_pkg::S_INIT: begin
                // directory entry 0 and slot 0 identity table
                dir_we    = 1'b1;
                dir_waddr = r_idx;
                dir_wdata = (r_idx == '0) ? {1'b1, {(DW-1){1'b0}}} : '0;
                tab_we    = 1'b1;
                tab_waddr = {{SW{1'b0}}, r_idx};
                tab_wdata = {1'b1, {(FW-IW){1'b0}}, r_idx};
                if (r_idx == '0) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = '0;
                    cnt_wdata = CW'(tplm_pkg::TABLE_ENTRIES);
                end
                n_idx = alu_rsp.res[IW-1:0];
                if (r_idx == IW'(tplm_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = tplm_pkg::S_IDLE;
                end
            end
            tplm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_status = tplm_pkg::ST_OK;
                    n_taken  = 1'b0;
                    n_inval  = 1'b0;
                    n_fpv    = 1'b0;
                    n_fpa    = '0;
                    n_ftv    = 1'b0;
                    n_fta    = '0;
                    n_state  = (i_op == tplm_pkg::OP_MAP) ? tplm_pkg::S_KCHK1
                                                          : tplm_pkg::S_DIR;
                end
            end
            tplm_pkg::S_KCHK1: begin
                alu_req.a   = r_va;
                alu_req.b   = r_kstart;
                alu_req.sub = 1'b1;
                n_ge    = !alu_rsp.borrow;
                n_state = tplm_pkg::S_KCHK2;
            end
            tplm_pkg::S_KCHK2: begin
                alu_req.a   = r_va;
                alu_req.b   = r_kend;
                alu_req.sub = 1'b1;
                if (r_ge && alu_rsp.borrow) begin
                    n_status = tplm_pkg::ST_KERNEL;
                    n_state  = tplm_pkg::S_OUT;
                end else begin
                    n_state  = tplm_pkg::S_DIR;
                end
            end
            tplm_pkg::S_DIR: begin
                n_state = tplm_pkg::S_DIRW;
            end
            tplm_pkg::S_DIRW: begin
                {n_dpres, n_dframe, n_dslot, n_ddyn} = dir_rdata;
                n_idx = '0;
                if (dir_rdata[DW-1]) begin
                    n_state = tplm_pkg::S_TRD;
                end else if (r_op == tplm_pkg::OP_UNMAP) begin
                    n_status = tplm_pkg::ST_NO_TABLE;
                    n_state  = tplm_pkg::S_OUT;
                end else if (r_spare == '0) begin
                    n_status = tplm_pkg::ST_NO_ALLOC;
                    n_state  = tplm_pkg::S_OUT;
                end else begin
                    n_state  = tplm_pkg::S_SRCH;
                end
            end
            tplm_pkg::S_SRCH: begin
                // lowest free slot, one per cycle
                n_idx = alu_rsp.res[IW-1:0];
                if (!r_busy[r_idx[SW-1:0]]) begin
                    n_slot  = r_idx[SW-1:0];
                    n_idx   = '0;
                    n_state = tplm_pkg::S_CLR;
                end else if (r_idx == IW'(TABLE_SLOTS - 1)) begin
                    n_status = tplm_pkg::ST_NO_ALLOC;
                    n_state  = tplm_pkg::S_OUT;
                end
            end
            tplm_pkg::S_CLR: begin
                tab_we    = 1'b1;
                tab_waddr = {r_slot, r_idx};
                tab_wdata = '0;
                n_idx     = alu_rsp.res[IW-1:0];
                if (r_idx == IW'(tplm_pkg::TABLE_ENTRIES - 1)) begin
                    dir_we    = 1'b1;
                    dir_wdata = {1'b1, r_spare[31:12], r_slot, 1'b1};
                    cnt_we    = 1'b1;
                    cnt_waddr = r_slot;
                    cnt_wdata = '0;
                    n_busy[r_slot] = 1'b1;
                    n_dpres   = 1'b1;
                    n_dframe  = r_spare[31:12];
                    n_dslot   = r_slot;
                    n_ddyn    = 1'b1;
                    n_taken   = 1'b1;
                    n_state   = tplm_pkg::S_TRD;
                end
            end
            tplm_pkg::S_TRD: begin
                n_state = tplm_pkg::S_TRW;
            end
            tplm_pkg::S_TRW: begin
                alu_req.a   = 32'(cnt_rdata);
                alu_req.b   = 32'd1;
                alu_req.sub = r_op;
                n_state     = tplm_pkg::S_OUT;
                if (r_op == tplm_pkg::OP_MAP) begin
                    tab_we    = 1'b1;
                    tab_wdata = {1'b1, r_pa[31:12]};
                    n_inval   = 1'b1;
                    if (!tab_rdata[TW-1] &&
                        cnt_rdata != CW'(tplm_pkg::TABLE_ENTRIES)) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = alu_rsp.res[CW-1:0];
                    end
                end else if (!tab_rdata[TW-1]) begin
                    n_status = tplm_pkg::ST_NOT_MAP;
                end else begin
                    tab_we    = 1'b1;
                    tab_wdata = '0;
                    n_inval   = 1'b1;
                    n_fpv     = 1'b1;
                    n_fpa     = tab_rdata[FW-1:0];
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_dec;
                    if (cnt_dec == '0 && r_ddyn) begin
                        // emptied dynamic table goes back to the pool
                        n_ftv     = 1'b1;
                        n_fta     = r_dframe;
                        dir_we    = 1'b1;
                        dir_wdata = '0;
                        n_busy[r_dslot] = 1'b0;
                    end
                end
            end
            tplm_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = tplm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tplm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid             = r_ovalid;
    assign o_status            = r_ostatus;
    assign o_spare_taken       = r_otaken;
    assign o_invalidate        = r_oinval;
    assign o_freed_page_valid  = r_ofpv;
    assign o_freed_page_addr   = {r_ofpa, 12'h000};
    assign o_freed_table_valid = r_oftv;
    assign o_freed_table_addr  = {r_ofta, 12'h000};

`include "two_level_page_table_manager_assert.svh"

    `TPLM_ASSERT(a_slot0_busy, r_state != tplm_pkg::S_INIT |-> r_busy[0], "slot 0 released")
    `TPLM_ASSERT(a_ft_needs_fp, o_valid && o_freed_table_valid |-> o_freed_page_valid,
        "table freed without page")
    `TPLM_ASSERT(a_taken_ok, o_valid && o_spare_taken |-> o_status == tplm_pkg::ST_OK,
        "spare taken on failure")
    `TPLM_ASSERT_NEXT(a_clr_exit, r_state == tplm_pkg::S_CLR,
        r_state == tplm_pkg::S_CLR || r_state == tplm_pkg::S_TRD, "bad exit from table clear")

endmodule
